// File: rtl/rsn_element_extractor_unit_assert.svh
// Assertion macros shared by the RTL.
`ifndef RSN_ELEMENT_EXTRACTOR_UNIT_ASSERT_SVH
`define RSN_ELEMENT_EXTRACTOR_UNIT_ASSERT_SVH

// pre holds -> post holds in the same cycle
`define REE_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// pre holds -> post holds in the next cycle
`define REE_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: rtl/ree_pkg.sv
package ree_pkg;

   localparam int MAX_PAIRWISE_KEPT_DEF = 2;
   localparam int MAX_AKM_KEPT_DEF      = 2;

   localparam logic [7:0] RSN_TAG     = 8'd48;
   localparam logic [7:0] RSN_MIN_LEN = 8'd8;

   localparam logic [1:0] ST_NOTFOUND = 2'd0;
   localparam logic [1:0] ST_FOUND    = 2'd1;
   localparam logic [1:0] ST_ERROR    = 2'd2;

   // suite list length fits in 255 element bytes: at most 63 entries
   localparam int CNT_W = 6;

   typedef enum logic [3:0] {
      PH_TAG,
      PH_LEN_OTHER,
      PH_SKIP,
      PH_LEN_RSN,
      PH_VER,
      PH_GROUP,
      PH_PCNT,
      PH_PSUITE,
      PH_ACNT,
      PH_ASUITE,
      PH_CAPS,
      PH_TAIL,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] rsn_version;
      logic [31:0] group_suite;
      logic [1:0]  pairwise_count;
      logic [31:0] pairwise_suite_0;
      logic [31:0] pairwise_suite_1;
      logic [1:0]  akm_count;
      logic [31:0] akm_suite_0;
      logic [31:0] akm_suite_1;
      logic [15:0] capabilities;
   } result_type;

endpackage

// File: rtl/ree_parser.sv
`include "rsn_element_extractor_unit_assert.svh"

module ree_parser import ree_pkg::*; #(
   parameter int MAX_PAIRWISE_KEPT = MAX_PAIRWISE_KEPT_DEF,
   parameter int MAX_AKM_KEPT      = MAX_AKM_KEPT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output result_type result
);

   phase_type        phase_ff, phase_in;
   logic [7:0]       left_ff, left_in;
   logic [7:0]       left_dec;
   logic [1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0] pw_total_ff, pw_total_in;
   logic [CNT_W-1:0] ak_total_ff, ak_total_in;
   logic [CNT_W-1:0] suite_ff, suite_in;
   logic [CNT_W-1:0] suite_nxt;
   logic [31:0]      shift_ff, shift_in;
   logic [31:0]      shift16, shift32;
   logic [1:0]       outcome_ff, outcome_in;
   logic [15:0]      ver_ff, ver_in;
   logic [31:0]      group_ff, group_in;
   logic [15:0]      caps_ff, caps_in;
   logic [31:0]      pw_kept_ff [MAX_PAIRWISE_KEPT];
   logic [31:0]      pw_kept_in [MAX_PAIRWISE_KEPT];
   logic [31:0]      ak_kept_ff [MAX_AKM_KEPT];
   logic [31:0]      ak_kept_in [MAX_AKM_KEPT];
   logic [17:0]      need;
   logic             fits;
   logic [CNT_W-1:0] pc, ac;
   phase_type        phase_end;
   logic [1:0]       status;

   always_comb begin
      left_dec  = left_ff - 8'd1;
      shift16   = idx_ff[0] ? (shift_ff | {16'd0, data_byte, 8'd0})
                            : (shift_ff | {24'd0, data_byte});
      shift32   = {shift_ff[23:0], data_byte};
      suite_nxt = suite_ff + CNT_W'(1);
      need      = {shift16[15:0], 2'b00} + 18'd2;
      fits      = {10'd0, left_dec} >= need;

      phase_in    = phase_ff;
      left_in     = left_ff;
      idx_in      = idx_ff;
      pw_total_in = pw_total_ff;
      ak_total_in = ak_total_ff;
      suite_in    = suite_ff;
      shift_in    = shift_ff;
      outcome_in  = outcome_ff;
      ver_in      = ver_ff;
      group_in    = group_ff;
      caps_in     = caps_ff;
      pw_kept_in  = pw_kept_ff;
      ak_kept_in  = ak_kept_ff;

      if (phase_ff >= PH_VER && phase_ff <= PH_TAIL) begin
         left_in = left_dec;
      end

      case (phase_ff)
         PH_TAG: begin
            phase_in = (data_byte == RSN_TAG) ? PH_LEN_RSN : PH_LEN_OTHER;
         end
         PH_LEN_OTHER: begin
            left_in  = data_byte;
            phase_in = (data_byte == 8'd0) ? PH_TAG : PH_SKIP;
         end
         PH_SKIP: begin
            left_in = left_dec;
            if (left_dec == 8'd0) begin
               phase_in = PH_TAG;
            end
         end
         PH_LEN_RSN: begin
            left_in = data_byte;
            if (data_byte < RSN_MIN_LEN) begin
               phase_in   = PH_DONE;
               outcome_in = ST_ERROR;
            end else begin
               phase_in = PH_VER;
               idx_in   = 2'd0;
               shift_in = 32'd0;
            end
         end
         PH_VER, PH_PCNT, PH_ACNT, PH_CAPS: begin
            shift_in = shift16;
            idx_in   = idx_ff + 2'd1;
            if (idx_ff[0]) begin
               idx_in   = 2'd0;
               shift_in = 32'd0;
               case (phase_ff)
                  PH_VER: begin
                     ver_in   = shift16[15:0];
                     phase_in = PH_GROUP;
                  end
                  PH_PCNT: begin
                     pw_total_in = shift16[CNT_W-1:0];
                     suite_in    = '0;
                     if (!fits) begin
                        phase_in   = PH_DONE;
                        outcome_in = ST_ERROR;
                     end else begin
                        phase_in = (shift16[15:0] == 16'd0) ? PH_ACNT : PH_PSUITE;
                     end
                  end
                  PH_ACNT: begin
                     ak_total_in = shift16[CNT_W-1:0];
                     suite_in    = '0;
                     if (!fits) begin
                        phase_in   = PH_DONE;
                        outcome_in = ST_ERROR;
                     end else begin
                        phase_in = (shift16[15:0] == 16'd0) ? PH_CAPS : PH_ASUITE;
                     end
                  end
                  default: begin
                     caps_in = shift16[15:0];
                     if (left_dec == 8'd0) begin
                        phase_in   = PH_DONE;
                        outcome_in = ST_FOUND;
                     end else begin
                        phase_in = PH_TAIL;
                     end
                  end
               endcase
            end
         end
         PH_GROUP, PH_PSUITE, PH_ASUITE: begin
            shift_in = shift32;
            idx_in   = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               idx_in   = 2'd0;
               shift_in = 32'd0;
               case (phase_ff)
                  PH_GROUP: begin
                     group_in = shift32;
                     phase_in = PH_PCNT;
                  end
                  PH_PSUITE: begin
                     for (int j = 0; j < MAX_PAIRWISE_KEPT; j++) begin
                        if (suite_ff == CNT_W'(j)) begin
                           pw_kept_in[j] = shift32;
                        end
                     end
                     suite_in = suite_nxt;
                     phase_in = (suite_nxt == pw_total_ff) ? PH_ACNT : PH_PSUITE;
                  end
                  default: begin
                     for (int j = 0; j < MAX_AKM_KEPT; j++) begin
                        if (suite_ff == CNT_W'(j)) begin
                           ak_kept_in[j] = shift32;
                        end
                     end
                     suite_in = suite_nxt;
                     phase_in = (suite_nxt == ak_total_ff) ? PH_CAPS : PH_ASUITE;
                  end
               endcase
            end
         end
         PH_TAIL: begin
            if (left_dec == 8'd0) begin
               phase_in   = PH_DONE;
               outcome_in = ST_FOUND;
            end
         end
         default: begin
         end
      endcase

      // status of the buffer as it stands after this byte
      phase_end = phase_in;
      if (phase_end == PH_DONE) begin
         status = outcome_in;
      end else if (phase_end >= PH_VER && phase_end <= PH_TAIL) begin
         status = ST_ERROR;
      end else begin
         status = ST_NOTFOUND;
      end

      pc = (pw_total_in > CNT_W'(MAX_PAIRWISE_KEPT)) ? CNT_W'(MAX_PAIRWISE_KEPT)
                                                     : pw_total_in;
      ac = (ak_total_in > CNT_W'(MAX_AKM_KEPT)) ? CNT_W'(MAX_AKM_KEPT) : ak_total_in;

      result        = '0;
      result.status = status;
      if (status == ST_FOUND) begin
         result.rsn_version    = ver_in;
         result.group_suite    = group_in;
         result.pairwise_count = pc[1:0];
         result.akm_count      = ac[1:0];
         result.capabilities   = caps_in;
         for (int j = 0; j < MAX_PAIRWISE_KEPT; j++) begin
            if (j == 0 && pc > CNT_W'(0)) result.pairwise_suite_0 = pw_kept_in[j];
            if (j == 1 && pc > CNT_W'(1)) result.pairwise_suite_1 = pw_kept_in[j];
         end
         for (int j = 0; j < MAX_AKM_KEPT; j++) begin
            if (j == 0 && ac > CNT_W'(0)) result.akm_suite_0 = ak_kept_in[j];
            if (j == 1 && ac > CNT_W'(1)) result.akm_suite_1 = ak_kept_in[j];
         end
      end

      // buffer end: back to the start of a new buffer
      if (last_byte) begin
         phase_in    = PH_TAG;
         left_in     = 8'd0;
         idx_in      = 2'd0;
         pw_total_in = '0;
         ak_total_in = '0;
         suite_in    = '0;
         shift_in    = 32'd0;
         outcome_in  = ST_NOTFOUND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TAG;
         left_ff     <= 8'd0;
         idx_ff      <= 2'd0;
         pw_total_ff <= '0;
         ak_total_ff <= '0;
         suite_ff    <= '0;
         shift_ff    <= 32'd0;
         outcome_ff  <= ST_NOTFOUND;
      end else if (step) begin
         phase_ff    <= phase_in;
         left_ff     <= left_in;
         idx_ff      <= idx_in;
         pw_total_ff <= pw_total_in;
         ak_total_ff <= ak_total_in;
         suite_ff    <= suite_in;
         shift_ff    <= shift_in;
         outcome_ff  <= outcome_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         ver_ff     <= ver_in;
         group_ff   <= group_in;
         caps_ff    <= caps_in;
         pw_kept_ff <= pw_kept_in;
         ak_kept_ff <= ak_kept_in;
      end
   end

   `REE_ASSERT_IMPLY(a_skip_left, clock, reset, phase_ff == PH_SKIP, left_ff != 8'd0,
                     "skip phase with no bytes left")
   `REE_ASSERT_IMPLY(a_psuite_idx, clock, reset, phase_ff == PH_PSUITE,
                     suite_ff < pw_total_ff, "pairwise suite index past count")
   `REE_ASSERT_IMPLY(a_done_outcome, clock, reset, phase_ff == PH_DONE,
                     outcome_ff == ST_FOUND || outcome_ff == ST_ERROR,
                     "settled without an outcome")

endmodule

// File: rtl/ree_out_reg.sv
module ree_out_reg import ree_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output result_type rsp_result
);

   logic       valid_ff, valid_in;
   result_type result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// File: rtl/rsn_element_extractor_unit.sv
// RSN element extractor.
// req channel: one byte of an information element buffer per transfer,
//   req_last_byte marks the final byte of the buffer.
// rsp channel: exactly one result transfer per buffer, after its last byte:
//   status (not found / found / error) and the parsed RSN fields, which are
//   zero unless the status is found.
// Throughput: one byte per cycle, sustained; only a last byte that meets a
//   stalled rsp side holding a result is held up, and later bytes wait behind it.
// Result path: the last byte is first captured in the input register; the result
//   register loads when the parser consumes that byte, which waits while rsp is stalled.
// Stall: while rsp_stall holds a pending result, the input register keeps
//   taking bytes and parsing goes on until it holds the next last byte;
//   req_stall rises only then.
// Reset: synchronous, active high; clears the parser to expect an element
//   tag and empties the input and result registers.
`include "rsn_element_extractor_unit_assert.svh"

module rsn_element_extractor_unit import ree_pkg::*; #(
   parameter int MAX_PAIRWISE_KEPT = MAX_PAIRWISE_KEPT_DEF,
   parameter int MAX_AKM_KEPT      = MAX_AKM_KEPT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_rsn_version,
   output logic [31:0] rsp_group_suite,
   output logic [1:0]  rsp_pairwise_count,
   output logic [31:0] rsp_pairwise_suite_0,
   output logic [31:0] rsp_pairwise_suite_1,
   output logic [1:0]  rsp_akm_count,
   output logic [31:0] rsp_akm_suite_0,
   output logic [31:0] rsp_akm_suite_1,
   output logic [15:0] rsp_capabilities
);

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_data_ff;
   logic       in_last_ff;

   logic       out_busy;   // result held by a stalled receiver
   logic       step;       // parser consumes the held byte
   logic       take;       // req transfer this cycle
   logic       out_load;
   result_type result;
   result_type rsp_result;

   assign out_busy  = rsp_valid && rsp_stall;
   // a last byte needs the result register free; other bytes always go
   assign step      = in_vld_ff && !(in_last_ff && out_busy);
   assign req_stall = in_vld_ff && !step;
   assign take      = req_valid && !req_stall;
   assign out_load  = step && in_last_ff;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (take) begin
         in_vld_in = 1'b1;
      end else if (step) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   ree_parser #(
      .MAX_PAIRWISE_KEPT (MAX_PAIRWISE_KEPT),
      .MAX_AKM_KEPT      (MAX_AKM_KEPT)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_data_ff),
      .last_byte (in_last_ff),
      .result    (result)
   );

   ree_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .result     (result),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   assign rsp_status           = rsp_result.status;
   assign rsp_rsn_version      = rsp_result.rsn_version;
   assign rsp_group_suite      = rsp_result.group_suite;
   assign rsp_pairwise_count   = rsp_result.pairwise_count;
   assign rsp_pairwise_suite_0 = rsp_result.pairwise_suite_0;
   assign rsp_pairwise_suite_1 = rsp_result.pairwise_suite_1;
   assign rsp_akm_count        = rsp_result.akm_count;
   assign rsp_akm_suite_0      = rsp_result.akm_suite_0;
   assign rsp_akm_suite_1      = rsp_result.akm_suite_1;
   assign rsp_capabilities     = rsp_result.capabilities;

   `REE_ASSERT_IMPLY(a_stall_needs_byte, clock, reset, req_stall, in_vld_ff,
                     "req stalled with an empty input register")
   `REE_ASSERT_IMPLY(a_no_overwrite, clock, reset, out_load, !out_busy,
                     "result register loaded while the receiver holds it")
   `REE_ASSERT_IMPLY(a_status_code, clock, reset, rsp_valid,
                     rsp_status == ST_NOTFOUND || rsp_status == ST_FOUND ||
                     rsp_status == ST_ERROR, "result with an undefined status")
   `REE_ASSERT_NEXT(a_load_shows, clock, reset, out_load, rsp_valid,
                    "loaded result not presented")

endmodule
